>>> hw/rtl/rx32_pkg.sv
package rx32_pkg;

    localparam int XLEN = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIX
    } t_state;

    // long operation held in the shared multiply/divide unit
    typedef enum logic [2:0] {
        L_MUL_LO,
        L_MUL_UU,
        L_MUL_SU,
        L_MUL_SS,
        L_DIV_U,
        L_DIV_S
    } t_long_op;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic ACT_INSN = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic [4:0] REG_RA = 5'd31;

    // primary opcodes
    localparam logic [5:0] OP_CALL    = 6'h00;
    localparam logic [5:0] OP_JMPI    = 6'h01;
    localparam logic [5:0] OP_LDBU    = 6'h03;
    localparam logic [5:0] OP_ADDI    = 6'h04;
    localparam logic [5:0] OP_STB     = 6'h05;
    localparam logic [5:0] OP_BR      = 6'h06;
    localparam logic [5:0] OP_LDB     = 6'h07;
    localparam logic [5:0] OP_CMPGEI  = 6'h08;
    localparam logic [5:0] OP_LDHU    = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_STH     = 6'h0d;
    localparam logic [5:0] OP_BGE     = 6'h0e;
    localparam logic [5:0] OP_LDH     = 6'h0f;
    localparam logic [5:0] OP_CMPLTI  = 6'h10;
    localparam logic [5:0] OP_ORI     = 6'h14;
    localparam logic [5:0] OP_STW     = 6'h15;
    localparam logic [5:0] OP_BLT     = 6'h16;
    localparam logic [5:0] OP_LDW     = 6'h17;
    localparam logic [5:0] OP_CMPNEI  = 6'h18;
    localparam logic [5:0] OP_XORI    = 6'h1c;
    localparam logic [5:0] OP_BNE     = 6'h1e;
    localparam logic [5:0] OP_CMPEQI  = 6'h20;
    localparam logic [5:0] OP_LDBUIO  = 6'h23;
    localparam logic [5:0] OP_MULI    = 6'h24;
    localparam logic [5:0] OP_STBIO   = 6'h25;
    localparam logic [5:0] OP_BEQ     = 6'h26;
    localparam logic [5:0] OP_LDBIO   = 6'h27;
    localparam logic [5:0] OP_CMPGEUI = 6'h28;
    localparam logic [5:0] OP_LDHUIO  = 6'h2b;
    localparam logic [5:0] OP_ANDHI   = 6'h2c;
    localparam logic [5:0] OP_STHIO   = 6'h2d;
    localparam logic [5:0] OP_BGEU    = 6'h2e;
    localparam logic [5:0] OP_LDHIO   = 6'h2f;
    localparam logic [5:0] OP_CMPLTUI = 6'h30;
    localparam logic [5:0] OP_INITDA  = 6'h33;
    localparam logic [5:0] OP_ORHI    = 6'h34;
    localparam logic [5:0] OP_STWIO   = 6'h35;
    localparam logic [5:0] OP_BLTU    = 6'h36;
    localparam logic [5:0] OP_LDWIO   = 6'h37;
    localparam logic [5:0] OP_RTYPE   = 6'h3a;
    localparam logic [5:0] OP_XORHI   = 6'h3c;

    // R-type extended opcodes
    localparam logic [5:0] X_ERET   = 6'h01;
    localparam logic [5:0] X_ROLI   = 6'h02;
    localparam logic [5:0] X_ROL    = 6'h03;
    localparam logic [5:0] X_FLUSHP = 6'h04;
    localparam logic [5:0] X_RET    = 6'h05;
    localparam logic [5:0] X_NOR    = 6'h06;
    localparam logic [5:0] X_MULXUU = 6'h07;
    localparam logic [5:0] X_CMPGE  = 6'h08;
    localparam logic [5:0] X_BRET   = 6'h09;
    localparam logic [5:0] X_ROR    = 6'h0b;
    localparam logic [5:0] X_FLUSHD = 6'h0c;
    localparam logic [5:0] X_JMP    = 6'h0d;
    localparam logic [5:0] X_AND    = 6'h0e;
    localparam logic [5:0] X_CMPLT  = 6'h10;
    localparam logic [5:0] X_SLLI   = 6'h12;
    localparam logic [5:0] X_SLL    = 6'h13;
    localparam logic [5:0] X_OR     = 6'h16;
    localparam logic [5:0] X_MULXSU = 6'h17;
    localparam logic [5:0] X_CMPNE  = 6'h18;
    localparam logic [5:0] X_SRLI   = 6'h1a;
    localparam logic [5:0] X_SRL    = 6'h1b;
    localparam logic [5:0] X_NEXTPC = 6'h1c;
    localparam logic [5:0] X_CALLR  = 6'h1d;
    localparam logic [5:0] X_XOR    = 6'h1e;
    localparam logic [5:0] X_MULXSS = 6'h1f;
    localparam logic [5:0] X_CMPEQ  = 6'h20;
    localparam logic [5:0] X_DIVU   = 6'h24;
    localparam logic [5:0] X_DIV    = 6'h25;
    localparam logic [5:0] X_RDCTL  = 6'h26;
    localparam logic [5:0] X_MUL    = 6'h27;
    localparam logic [5:0] X_CMPGEU = 6'h28;
    localparam logic [5:0] X_INITI  = 6'h29;
    localparam logic [5:0] X_WRCTL  = 6'h2e;
    localparam logic [5:0] X_CMPLTU = 6'h30;
    localparam logic [5:0] X_ADD    = 6'h31;
    localparam logic [5:0] X_FLUSHI = 6'h36;
    localparam logic [5:0] X_SUB    = 6'h39;
    localparam logic [5:0] X_SRAI   = 6'h3a;
    localparam logic [5:0] X_SRA    = 6'h3b;

endpackage

>>> hw/rtl/rx32_if.sv
interface rx32_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [rx32_pkg::XLEN-1:0]  word;

    modport source (output valid, output action, output word, input ready);
    modport sink   (input valid, input action, input word, output ready);
endinterface

interface rx32_out_if;
    logic                       valid;
    logic                       ready;
    logic [rx32_pkg::XLEN-1:0]  next_pc;
    logic [1:0]                 mem_kind;
    logic [1:0]                 mem_size;
    logic [rx32_pkg::XLEN-1:0]  mem_address;
    logic [rx32_pkg::XLEN-1:0]  mem_write_data;
    logic                       awaiting_load;
    logic                       illegal_opcode;

    modport source (output valid, output next_pc, output mem_kind, output mem_size,
                    output mem_address, output mem_write_data, output awaiting_load,
                    output illegal_opcode, input ready);
    modport sink   (input valid, input next_pc, input mem_kind, input mem_size,
                    input mem_address, input mem_write_data, input awaiting_load,
                    input illegal_opcode, output ready);
endinterface

>>> hw/rtl/risc32_integer_execute_core_top.sv
// 32-bit RISC integer execute core. Each input transfer is either a fetched
// instruction word (action 0) or the data answering a pending load (action 1);
// each one produces exactly one result transfer with the next fetch PC, any
// memory request and the load-wait / illegal-opcode flags. The core is strictly
// one item at a time: ready is high only while the sequencer is idle. A plain
// item passes the transfer, where the two-port register file read is
// launched, then the execute state through the ALU/shifter. Multiply (mul, muli,
// mulx*) and divide (div, divu) run on one shared shift-add / restoring-subtract
// unit, one bit per cycle, then a fix-up state writes the result. The result sits
// in an output register, so a new item can be taken while it waits; a full
// output register with no ready stalls the final step. No clearing pass: the
// general registers carry one valid bit each, reset clears them at once.
module risc32_integer_execute_core_top #(
    parameter int CONTROL_REG_COUNT = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rx32_in_if.sink        i_in,
    rx32_out_if.source     o_out
);

    localparam int CW = (CONTROL_REG_COUNT > 1) ? $clog2(CONTROL_REG_COUNT) : 1;

    rx32_pkg::t_state   r_state, n_state;
    rx32_pkg::t_long_op r_lop;

    // general register file: 2 registered read ports, 1 write port
    logic [31:0] r_gpr [32];
    logic [31:0] r_gpr_vld;
    logic [31:0] r_rd_a, r_rd_b;
    logic        r_a_ok, r_b_ok;

    logic [31:0] r_ctl [CONTROL_REG_COUNT];

    logic [31:0] r_pc;
    logic        r_ld_pend;
    logic [4:0]  r_ld_dst;
    logic [1:0]  r_ld_size;
    logic        r_ld_sig;

    logic        r_act;
    logic [31:0] r_word;

    // shared multiply/divide unit
    logic [31:0] r_hi, r_lo, r_mcand;
    logic [4:0]  r_cnt;
    logic [4:0]  r_dst;
    logic        r_neg, r_dz;

    // output register
    logic        r_ovld;
    logic [31:0] r_o_pc, r_o_addr, r_o_data;
    logic [1:0]  r_o_kind, r_o_size;
    logic        r_o_await, r_o_ill;

    logic        acc, out_free;
    logic [31:0] a, b;

    // execute-stage decode
    logic [5:0]  op, opx;
    logic [4:0]  bi, ci, imm5, sh;
    logic [15:0] imm;
    logic [31:0] simm, pc4, br_tgt, ea, sh_in, sh_rot;

    // commit controls
    logic        c_commit, c_long, c_div;
    logic        c_wr, c_ctl_wr, c_ld_set, c_ld_clr, c_ill, c_await;
    logic [4:0]  c_idx;
    logic [31:0] c_val, c_next, c_addr, c_data;
    logic [1:0]  c_kind, c_size, c_ld_size;
    logic        c_ld_sig;
    rx32_pkg::t_long_op c_lop;
    logic [31:0] c_mul_b;

    logic [32:0] mul_sum, div_t, div_d;
    logic [31:0] fix_val;

    assign acc      = i_in.valid && i_in.ready;
    assign out_free = !r_ovld || o_out.ready;
    assign a        = r_a_ok ? r_rd_a : '0;
    assign b        = r_b_ok ? r_rd_b : '0;

    assign i_in.ready = (r_state == rx32_pkg::S_IDLE);

    assign o_out.valid          = r_ovld;
    assign o_out.next_pc        = r_o_pc;
    assign o_out.mem_kind       = r_o_kind;
    assign o_out.mem_size       = r_o_size;
    assign o_out.mem_address    = r_o_addr;
    assign o_out.mem_write_data = r_o_data;
    assign o_out.awaiting_load  = r_o_await;
    assign o_out.illegal_opcode = r_o_ill;

    function automatic logic [31:0] f_rotl(input logic [31:0] x, input logic [4:0] s);
        f_rotl = (x << s) | (x >> (6'd32 - {1'b0, s}));
    endfunction

    // ---------------- field split ----------------
    assign op     = r_word[5:0];
    assign opx    = r_word[16:11];
    assign bi     = r_word[26:22];
    assign ci     = r_word[21:17];
    assign imm5   = r_word[10:6];
    assign imm    = r_word[21:6];
    assign simm   = {{16{imm[15]}}, imm};
    assign pc4    = r_pc + 32'd4;
    assign br_tgt = pc4 + simm;
    assign ea     = a + simm;

    // shared shifter: rotate left, with right rotate derived from it; shifts use the same shift amount
    assign sh     = (opx == rx32_pkg::X_ROLI || opx == rx32_pkg::X_SLLI ||
                     opx == rx32_pkg::X_SRLI || opx == rx32_pkg::X_SRAI) ? imm5 : b[4:0];
    assign sh_in  = a;
    assign sh_rot = f_rotl(sh_in, (opx == rx32_pkg::X_ROR) ? 5'(5'd0 - sh) : sh);

    // ---------------- multiply / divide datapath ----------------
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : 33'd0);
    assign div_t   = {r_hi, r_lo[31]};
    assign div_d   = div_t - {1'b0, r_mcand};

    always_comb begin
        case (r_lop)
            rx32_pkg::L_MUL_LO: fix_val = r_lo;
            rx32_pkg::L_MUL_UU: fix_val = r_hi;
            rx32_pkg::L_MUL_SU: fix_val = r_hi - (a[31] ? b : 32'd0);
            rx32_pkg::L_MUL_SS: fix_val = r_hi - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);
            rx32_pkg::L_DIV_U,
            rx32_pkg::L_DIV_S:  fix_val = r_dz ? 32'hffff_ffff :
                                          (r_neg ? 32'd0 - r_lo : r_lo);
            default:            fix_val = r_lo;
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rx32_pkg::S_IDLE: if (acc) n_state = rx32_pkg::S_EXEC;
            rx32_pkg::S_EXEC: begin
                if (c_long) n_state = c_div ? rx32_pkg::S_DIV : rx32_pkg::S_MUL;
                else if (out_free) n_state = rx32_pkg::S_IDLE;
            end
            rx32_pkg::S_MUL,
            rx32_pkg::S_DIV:  if (r_cnt == 5'd31) n_state = rx32_pkg::S_FIX;
            rx32_pkg::S_FIX:  if (out_free) n_state = rx32_pkg::S_IDLE;
            default:          n_state = rx32_pkg::S_IDLE;
        endcase
    end

    // ---------------- execute / commit decode ----------------
    always_comb begin
        c_commit  = 1'b0;
        c_long    = 1'b0;
        c_div     = 1'b0;
        c_lop     = rx32_pkg::L_MUL_LO;
        c_mul_b   = b;
        c_wr      = 1'b0;
        c_idx     = bi;
        c_val     = '0;
        c_ctl_wr  = 1'b0;
        c_ld_set  = 1'b0;
        c_ld_clr  = 1'b0;
        c_ld_size = rx32_pkg::SIZE_BYTE;
        c_ld_sig  = 1'b0;
        c_next    = pc4;
        c_kind    = rx32_pkg::KIND_NONE;
        c_size    = rx32_pkg::SIZE_BYTE;
        c_addr    = '0;
        c_data    = '0;
        c_ill     = 1'b0;
        c_await   = r_ld_pend;

        if (r_state == rx32_pkg::S_FIX) begin
            c_commit = out_free;
            c_wr     = 1'b1;
            c_idx    = r_dst;
            c_val    = fix_val;
        end else if (r_state == rx32_pkg::S_EXEC) begin
            if (r_act == rx32_pkg::ACT_LOAD) begin
                c_next = r_pc;
                if (r_ld_pend) begin
                    c_ld_clr = 1'b1;
                    c_await  = 1'b0;
                    c_wr     = 1'b1;
                    c_idx    = r_ld_dst;
                    case (r_ld_size)
                        rx32_pkg::SIZE_BYTE:
                            c_val = {{24{r_ld_sig & r_word[7]}}, r_word[7:0]};
                        rx32_pkg::SIZE_HALF:
                            c_val = {{16{r_ld_sig & r_word[15]}}, r_word[15:0]};
                        default: c_val = r_word;
                    endcase
                end
            end else if (r_ld_pend) begin
                // instruction while a load is outstanding is dropped
                c_next = r_pc;
            end else begin
                case (op)
                    rx32_pkg::OP_CALL: begin
                        c_wr   = 1'b1;
                        c_idx  = rx32_pkg::REG_RA;
                        c_val  = pc4;
                        c_next = {r_pc[31:28], r_word[31:4]};
                    end
                    rx32_pkg::OP_JMPI: c_next = {r_pc[31:28], r_word[31:4]};
                    rx32_pkg::OP_LDBU, rx32_pkg::OP_LDBUIO: begin
                        c_ld_set = 1'b1; c_ld_size = rx32_pkg::SIZE_BYTE;
                    end
                    rx32_pkg::OP_LDB, rx32_pkg::OP_LDBIO: begin
                        c_ld_set = 1'b1; c_ld_size = rx32_pkg::SIZE_BYTE; c_ld_sig = 1'b1;
                    end
                    rx32_pkg::OP_LDHU, rx32_pkg::OP_LDHUIO: begin
                        c_ld_set = 1'b1; c_ld_size = rx32_pkg::SIZE_HALF;
                    end
                    rx32_pkg::OP_LDH, rx32_pkg::OP_LDHIO: begin
                        c_ld_set = 1'b1; c_ld_size = rx32_pkg::SIZE_HALF; c_ld_sig = 1'b1;
                    end
                    rx32_pkg::OP_LDW, rx32_pkg::OP_LDWIO: begin
                        c_ld_set = 1'b1; c_ld_size = rx32_pkg::SIZE_WORD;
                    end
                    rx32_pkg::OP_STB, rx32_pkg::OP_STBIO: begin
                        c_kind = rx32_pkg::KIND_WRITE; c_size = rx32_pkg::SIZE_BYTE;
                        c_addr = ea; c_data = {24'd0, b[7:0]};
                    end
                    rx32_pkg::OP_STH, rx32_pkg::OP_STHIO: begin
                        c_kind = rx32_pkg::KIND_WRITE; c_size = rx32_pkg::SIZE_HALF;
                        c_addr = ea; c_data = {16'd0, b[15:0]};
                    end
                    rx32_pkg::OP_STW, rx32_pkg::OP_STWIO: begin
                        c_kind = rx32_pkg::KIND_WRITE; c_size = rx32_pkg::SIZE_WORD;
                        c_addr = ea; c_data = b;
                    end
                    rx32_pkg::OP_ADDI:   begin c_wr = 1'b1; c_val = ea; end
                    rx32_pkg::OP_BR:     c_next = br_tgt;
                    rx32_pkg::OP_CMPGEI: begin
                        c_wr = 1'b1; c_val = {31'd0, !($signed(a) < $signed(simm))};
                    end
                    rx32_pkg::OP_ANDI:   begin c_wr = 1'b1; c_val = a & {16'd0, imm}; end
                    rx32_pkg::OP_BGE:    if (!($signed(a) < $signed(b))) c_next = br_tgt;
                    rx32_pkg::OP_CMPLTI: begin
                        c_wr = 1'b1; c_val = {31'd0, $signed(a) < $signed(simm)};
                    end
                    rx32_pkg::OP_ORI:    begin c_wr = 1'b1; c_val = a | {16'd0, imm}; end
                    rx32_pkg::OP_BLT:    if ($signed(a) < $signed(b)) c_next = br_tgt;
                    rx32_pkg::OP_CMPNEI: begin c_wr = 1'b1; c_val = {31'd0, a != simm}; end
                    rx32_pkg::OP_XORI:   begin c_wr = 1'b1; c_val = a ^ {16'd0, imm}; end
                    rx32_pkg::OP_BNE:    if (a != b) c_next = br_tgt;
                    rx32_pkg::OP_CMPEQI: begin c_wr = 1'b1; c_val = {31'd0, a == simm}; end
                    rx32_pkg::OP_MULI: begin
                        c_long = 1'b1; c_lop = rx32_pkg::L_MUL_LO; c_mul_b = simm;
                    end
                    rx32_pkg::OP_BEQ:    if (a == b) c_next = br_tgt;
                    rx32_pkg::OP_CMPGEUI: begin
                        c_wr = 1'b1; c_val = {31'd0, a >= {16'd0, imm}};
                    end
                    rx32_pkg::OP_ANDHI:  begin c_wr = 1'b1; c_val = a & {imm, 16'd0}; end
                    rx32_pkg::OP_BGEU:   if (a >= b) c_next = br_tgt;
                    rx32_pkg::OP_CMPLTUI: begin
                        c_wr = 1'b1; c_val = {31'd0, a < {16'd0, imm}};
                    end
                    rx32_pkg::OP_INITDA: ;
                    rx32_pkg::OP_ORHI:   begin c_wr = 1'b1; c_val = a | {imm, 16'd0}; end
                    rx32_pkg::OP_BLTU:   if (a < b) c_next = br_tgt;
                    rx32_pkg::OP_XORHI:  begin c_wr = 1'b1; c_val = a ^ {imm, 16'd0}; end
                    rx32_pkg::OP_RTYPE: begin
                        c_idx = ci;
                        case (opx)
                            rx32_pkg::X_ERET, rx32_pkg::X_RET,
                            rx32_pkg::X_BRET, rx32_pkg::X_JMP: c_next = a;
                            rx32_pkg::X_ROLI, rx32_pkg::X_ROL, rx32_pkg::X_ROR: begin
                                c_wr = 1'b1; c_val = sh_rot;
                            end
                            rx32_pkg::X_NOR:  begin c_wr = 1'b1; c_val = ~(a | b); end
                            rx32_pkg::X_MULXUU: begin c_long = 1'b1; c_lop = rx32_pkg::L_MUL_UU; end
                            rx32_pkg::X_MULXSU: begin c_long = 1'b1; c_lop = rx32_pkg::L_MUL_SU; end
                            rx32_pkg::X_MULXSS: begin c_long = 1'b1; c_lop = rx32_pkg::L_MUL_SS; end
                            rx32_pkg::X_MUL:    begin c_long = 1'b1; c_lop = rx32_pkg::L_MUL_LO; end
                            rx32_pkg::X_DIVU: begin
                                c_long = 1'b1; c_div = 1'b1; c_lop = rx32_pkg::L_DIV_U;
                            end
                            rx32_pkg::X_DIV: begin
                                c_long = 1'b1; c_div = 1'b1; c_lop = rx32_pkg::L_DIV_S;
                            end
                            rx32_pkg::X_CMPGE: begin
                                c_wr = 1'b1; c_val = {31'd0, !($signed(a) < $signed(b))};
                            end
                            rx32_pkg::X_CMPLT: begin
                                c_wr = 1'b1; c_val = {31'd0, $signed(a) < $signed(b)};
                            end
                            rx32_pkg::X_AND:  begin c_wr = 1'b1; c_val = a & b; end
                            rx32_pkg::X_OR:   begin c_wr = 1'b1; c_val = a | b; end
                            rx32_pkg::X_XOR:  begin c_wr = 1'b1; c_val = a ^ b; end
                            rx32_pkg::X_SLLI, rx32_pkg::X_SLL: begin
                                c_wr = 1'b1; c_val = a << sh;
                            end
                            rx32_pkg::X_SRLI, rx32_pkg::X_SRL: begin
                                c_wr = 1'b1; c_val = a >> sh;
                            end
                            rx32_pkg::X_SRAI, rx32_pkg::X_SRA: begin
                                c_wr = 1'b1; c_val = 32'($signed(a) >>> sh);
                            end
                            rx32_pkg::X_CMPNE:  begin c_wr = 1'b1; c_val = {31'd0, a != b}; end
                            rx32_pkg::X_CMPEQ:  begin c_wr = 1'b1; c_val = {31'd0, a == b}; end
                            rx32_pkg::X_CMPGEU: begin c_wr = 1'b1; c_val = {31'd0, a >= b}; end
                            rx32_pkg::X_CMPLTU: begin c_wr = 1'b1; c_val = {31'd0, a < b}; end
                            rx32_pkg::X_NEXTPC: begin c_wr = 1'b1; c_val = pc4; end
                            rx32_pkg::X_CALLR: begin
                                c_wr = 1'b1; c_val = pc4; c_next = a;
                            end
                            rx32_pkg::X_RDCTL: begin
                                c_wr  = 1'b1;
                                c_val = ({1'b0, imm5} < 6'(CONTROL_REG_COUNT))
                                        ? r_ctl[imm5[CW-1:0]] : 32'd0;
                            end
                            rx32_pkg::X_WRCTL:
                                c_ctl_wr = ({1'b0, imm5} < 6'(CONTROL_REG_COUNT));
                            rx32_pkg::X_ADD: begin c_wr = 1'b1; c_val = a + b; end
                            rx32_pkg::X_SUB: begin c_wr = 1'b1; c_val = a - b; end
                            rx32_pkg::X_FLUSHP, rx32_pkg::X_FLUSHD,
                            rx32_pkg::X_INITI, rx32_pkg::X_FLUSHI: ;
                            default: c_ill = 1'b1;
                        endcase
                    end
                    default: c_ill = 1'b1;
                endcase
                if (c_ld_set) begin
                    c_kind  = rx32_pkg::KIND_READ;
                    c_size  = c_ld_size;
                    c_addr  = ea;
                    c_await = 1'b1;
                end
            end
            c_commit = out_free && !c_long;
        end
    end

    // ---------------- register file ----------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_a <= r_gpr[i_in.word[31:27]];
            r_rd_b <= r_gpr[i_in.word[26:22]];
        end
        if (c_commit && c_wr && c_idx != 5'd0) begin
            r_gpr[c_idx] <= c_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpr_vld <= '0;
            r_a_ok    <= 1'b0;
            r_b_ok    <= 1'b0;
        end else begin
            if (acc) begin
                r_a_ok <= r_gpr_vld[i_in.word[31:27]];
                r_b_ok <= r_gpr_vld[i_in.word[26:22]];
            end
            if (c_commit && c_wr && c_idx != 5'd0) begin
                r_gpr_vld[c_idx] <= 1'b1;
            end
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rx32_pkg::S_IDLE;
            r_pc      <= '0;
            r_ld_pend <= 1'b0;
            r_ld_dst  <= '0;
            r_ld_size <= rx32_pkg::SIZE_BYTE;
            r_ld_sig  <= 1'b0;
            r_ovld    <= 1'b0;
            r_cnt     <= '0;
            for (int i = 0; i < CONTROL_REG_COUNT; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == rx32_pkg::S_MUL || r_state == rx32_pkg::S_DIV) begin
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_cnt <= '0;
            end
            if (c_commit) begin
                r_ovld <= 1'b1;
                r_pc   <= c_next;
                if (c_ctl_wr) r_ctl[imm5[CW-1:0]] <= a;
                if (c_ld_set) begin
                    r_ld_pend <= 1'b1;
                    r_ld_dst  <= bi;
                    r_ld_size <= c_ld_size;
                    r_ld_sig  <= c_ld_sig;
                end else if (c_ld_clr) begin
                    r_ld_pend <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_act  <= i_in.action;
            r_word <= i_in.word;
        end
        if (c_commit) begin
            r_o_pc    <= c_next;
            r_o_kind  <= c_kind;
            r_o_size  <= c_size;
            r_o_addr  <= c_addr;
            r_o_data  <= c_data;
            r_o_await <= c_await;
            r_o_ill   <= c_ill;
        end
        if (r_state == rx32_pkg::S_EXEC && c_long) begin
            r_lop <= c_lop;
            r_dst <= c_idx;
            r_hi  <= '0;
            r_dz  <= (b == 32'd0);
            if (c_div) begin
                // signed divide works on magnitudes, sign applied at the end
                r_neg   <= (c_lop == rx32_pkg::L_DIV_S) && (a[31] ^ b[31]);
                r_lo    <= (c_lop == rx32_pkg::L_DIV_S && a[31]) ? 32'd0 - a : a;
                r_mcand <= (c_lop == rx32_pkg::L_DIV_S && b[31]) ? 32'd0 - b : b;
            end else begin
                r_neg   <= 1'b0;
                r_lo    <= c_mul_b;
                r_mcand <= a;
            end
        end else if (r_state == rx32_pkg::S_MUL) begin
            r_hi <= mul_sum[32:1];
            r_lo <= {mul_sum[0], r_lo[31:1]};
        end else if (r_state == rx32_pkg::S_DIV) begin
            if (!div_d[32]) begin
                r_hi <= div_d[31:0];
            end else begin
                r_hi <= div_t[31:0];
            end
            r_lo <= {r_lo[30:0], !div_d[32]};
        end
    end

`ifndef SYNTH
    // register 0 never becomes a live entry
    a_r0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gpr_vld[0])
        else $error("register 0 marked written");

    // a load request always leaves the core waiting for data
    a_load_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_o_kind == rx32_pkg::KIND_READ |-> r_o_await && r_ld_pend)
        else $error("load issued without pending state");

    // after a transfer the core is not ready again in the following cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !i_in.ready)
        else $error("second item taken while busy");

    // the iteration counter only runs inside the multiply/divide states
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rx32_pkg::S_EXEC |-> r_cnt == 5'd0)
        else $error("iteration counter not cleared");
`endif

endmodule
